// File: rtl/dtsr_pkg.sv
// Shared types and constants for the decode timestamp reorder block.
`timescale 1ns / 1ps

package dtsr_pkg;

   localparam int TS_W = 64;
   localparam logic [TS_W-1:0] TS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef logic [TS_W-1:0] ts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_LAST_RD,
      ST_FIX,
      ST_G_DTS,
      ST_G_CLAMP,
      ST_G_MONO,
      ST_G_RAISE,
      ST_EMIT
   } state_type;

   // Operands of the shared compare and increment unit.
   typedef struct packed {
      ts_type a;
      ts_type b;
   } alu_in_type;

   // lt is the signed a < b; inc is a + 1, saturating at the largest value.
   typedef struct packed {
      logic   lt;
      ts_type inc;
   } alu_res_type;

endpackage

// File: rtl/dtsr_alu.sv
// Shared signed compare and saturating increment unit.
`timescale 1ns / 1ps

module dtsr_alu
   import dtsr_pkg::*;
(
   input  alu_in_type  alu_op,
   output alu_res_type alu_res
);

   always_comb begin
      alu_res.lt  = $signed(alu_op.a) < $signed(alu_op.b);
      alu_res.inc = (alu_op.a == TS_MAX) ? alu_op.a : alu_op.a + ts_type'(1);
   end

endmodule

// File: rtl/dts_reorder_synthesizer.sv
// Top level: packet reorder buffer and decode timestamp guard sequencer.
//
//  Channel   Direction  Handshake               Payload
//  req_      in         req_tvalid/req_tready   tdata packet fields, tuser func
//  rsp_      out        rsp_tvalid/rsp_tready   tdata packet fields, tlast
//  csr_      in         csr_valid/csr_ready     csr_data passthrough mode
//
// A bypassed push passes through the guard states; a push that only stores writes the FIFO and pool.
// Each packet that leaves the buffer first needs a pool minimum scan, which reads the buffered
// packets one at a time through the single pool read port, and then passes through the guard states.
// A flush repeats that for every buffered packet.
// Reset is synchronous; it empties the buffer and clears the previous dts.
// A stalled result waits in the output register; the sequencer holds there.
`timescale 1ns / 1ps

module dts_reorder_synthesizer
   import dtsr_pkg::*;
#(
   parameter int REORDER_DEPTH_P = 6,
   parameter int TAG_BITS        = 16,
   localparam int REQ_W = ((TAG_BITS + 2 * TS_W + 2 + 7) / 8) * 8,
   localparam int RSP_W = ((TAG_BITS + 2 * TS_W + 1 + 7) / 8) * 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // tag_in, pts_in, pts_in_valid, dts_in, dts_in_valid, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // func
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // tag_out, pts_out, pts_out_valid, dts_out, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   localparam int SLOTS = REORDER_DEPTH_P + 1;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Input fields.
   logic [TAG_BITS-1:0] f_tag;
   ts_type              f_pts;
   logic                f_pv;
   ts_type              f_dts;
   logic                f_dv;

   assign f_tag = req_tdata[TAG_BITS-1:0];
   assign f_pts = req_tdata[TAG_BITS +: TS_W];
   assign f_pv  = req_tdata[TAG_BITS + TS_W];
   assign f_dts = req_tdata[TAG_BITS + TS_W + 1 +: TS_W];
   assign f_dv  = req_tdata[TAG_BITS + 2 * TS_W + 1];

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] mi_ff, mi_in;
   ts_type           min_ff, min_in;
   logic             mode_ff, mode_in;
   ts_type           prev_dts_ff, prev_dts_in;
   logic             prev_valid_ff, prev_valid_in;
   logic             flush_ff, flush_in;

   // Packet under the guard.
   logic [TAG_BITS-1:0] g_tag_ff, g_tag_in;
   ts_type              g_pts_ff, g_pts_in;
   logic                g_pv_ff, g_pv_in;
   ts_type              g_dts_ff, g_dts_in;
   logic                g_dv_ff, g_dv_in;
   logic                g_last_ff, g_last_in;

   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic             rsp_tlast_ff, rsp_tlast_in;

   // Packet FIFO in arrival order and the pool of buffered pts values.
   logic [TAG_BITS-1:0] fifo_tag_ff [SLOTS];
   ts_type              fifo_pts_ff [SLOTS];
   logic                fifo_pv_ff  [SLOTS];
   ts_type              pool_mem_ff [SLOTS];
   ts_type              pool_rdata_ff;

   logic             fifo_we;
   logic             pool_we;
   logic [IDX_W-1:0] pool_waddr;
   ts_type           pool_wdata;
   logic [IDX_W-1:0] pool_raddr;
   logic [CNT_W:0]   tail_sum;
   logic [IDX_W-1:0] tail;
   ts_type           push_pts;

   alu_in_type  alu_op;
   alu_res_type alu_res;

   dtsr_alu u_alu (
      .alu_op  (alu_op),
      .alu_res (alu_res)
   );

   assign tail_sum = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
   assign tail     = (tail_sum >= (CNT_W + 1)'(SLOTS)) ?
                     IDX_W'(tail_sum - (CNT_W + 1)'(SLOTS)) : IDX_W'(tail_sum);
   assign push_pts = f_pv ? f_pts : '0;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   always_comb begin
      pool_raddr = (state_ff == ST_LAST_RD) ? IDX_W'(count_ff - 1'b1) : idx_ff;
   end

   always_comb begin
      unique case (state_ff)
         ST_SCAN_CMP: begin
            alu_op.a = pool_rdata_ff;
            alu_op.b = min_ff;
         end
         ST_G_DTS, ST_G_MONO: begin
            alu_op.a = prev_dts_ff;
            alu_op.b = g_dts_ff;
         end
         default: begin
            alu_op.a = g_pts_ff;
            alu_op.b = g_dts_ff;
         end
      endcase
   end

   // Next state and datapath control.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      idx_in        = idx_ff;
      mi_in         = mi_ff;
      min_in        = min_ff;
      mode_in       = csr_valid ? csr_data : mode_ff;
      prev_dts_in   = prev_dts_ff;
      prev_valid_in = prev_valid_ff;
      flush_in      = flush_ff;
      g_tag_in      = g_tag_ff;
      g_pts_in      = g_pts_ff;
      g_pv_in       = g_pv_ff;
      g_dts_in      = g_dts_ff;
      g_dv_in       = g_dv_ff;
      g_last_in     = g_last_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      fifo_we       = 1'b0;
      pool_we       = 1'b0;
      pool_waddr    = IDX_W'(count_ff);
      pool_wdata    = push_pts;

      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_tvalid) begin
               flush_in = req_tuser;
               if (req_tuser) begin
                  state_in = (count_ff == '0) ? ST_IDLE : ST_SCAN_RD;
               end else if (mode_ff || (f_dv && count_ff == '0)) begin
                  g_tag_in  = f_tag;
                  g_pts_in  = push_pts;
                  g_pv_in   = f_pv;
                  g_dts_in  = f_dts;
                  g_dv_in   = f_dv;
                  g_last_in = 1'b1;
                  state_in  = ST_G_DTS;
               end else begin
                  fifo_we  = 1'b1;
                  pool_we  = 1'b1;
                  count_in = count_ff + 1'b1;
                  state_in = (count_ff == CNT_W'(REORDER_DEPTH_P)) ? ST_SCAN_RD : ST_IDLE;
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            // The first entry seeds the minimum; ties keep the earlier entry.
            if (idx_ff == '0 || alu_res.lt) begin
               min_in = pool_rdata_ff;
               mi_in  = idx_ff;
            end
            if (CNT_W'(idx_ff) == count_ff - 1'b1) begin
               state_in = ST_LAST_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_LAST_RD: begin
            state_in = ST_FIX;
         end
         ST_FIX: begin
            // The last pool entry fills the hole left by the minimum.
            pool_we    = 1'b1;
            pool_waddr = mi_ff;
            pool_wdata = pool_rdata_ff;
            g_tag_in   = fifo_tag_ff[head_ff];
            g_pts_in   = fifo_pts_ff[head_ff];
            g_pv_in    = fifo_pv_ff[head_ff];
            g_dts_in   = min_ff;
            g_dv_in    = 1'b1;
            g_last_in  = flush_ff ? (count_ff == CNT_W'(1)) : 1'b1;
            count_in   = count_ff - 1'b1;
            head_in    = (head_ff == IDX_W'(SLOTS - 1)) ? '0 : head_ff + 1'b1;
            idx_in     = '0;
            state_in   = ST_G_DTS;
         end
         ST_G_DTS: begin
            if (!g_dv_ff) begin
               if (g_pv_ff) begin
                  g_dts_in = g_pts_ff;
               end else begin
                  g_dts_in = prev_valid_ff ? alu_res.inc : '0;
               end
            end
            state_in = ST_G_CLAMP;
         end
         ST_G_CLAMP: begin
            if (g_pv_ff && alu_res.lt) begin
               g_dts_in = g_pts_ff;
            end
            state_in = ST_G_MONO;
         end
         ST_G_MONO: begin
            if (prev_valid_ff && !alu_res.lt) begin
               g_dts_in = alu_res.inc;
            end
            state_in = ST_G_RAISE;
         end
         ST_G_RAISE: begin
            if (g_pv_ff && alu_res.lt) begin
               g_pts_in = g_dts_ff;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tdata_in[TAG_BITS-1:0]              = g_tag_ff;
               rsp_tdata_in[TAG_BITS +: TS_W]          = g_pts_ff;
               rsp_tdata_in[TAG_BITS + TS_W]           = g_pv_ff;
               rsp_tdata_in[TAG_BITS + TS_W + 1 +: TS_W] = g_dts_ff;
               rsp_tlast_in  = g_last_ff;
               prev_dts_in   = g_dts_ff;
               prev_valid_in = 1'b1;
               idx_in        = '0;
               state_in      = (flush_ff && count_ff != '0) ? ST_SCAN_RD : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         head_ff       <= '0;
         mode_ff       <= 1'b0;
         prev_dts_ff   <= '0;
         prev_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         mode_ff       <= mode_in;
         prev_dts_ff   <= prev_dts_in;
         prev_valid_ff <= prev_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      mi_ff        <= mi_in;
      min_ff       <= min_in;
      flush_ff     <= flush_in;
      g_tag_ff     <= g_tag_in;
      g_pts_ff     <= g_pts_in;
      g_pv_ff      <= g_pv_in;
      g_dts_ff     <= g_dts_in;
      g_dv_ff      <= g_dv_in;
      g_last_ff    <= g_last_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_tag_ff[tail] <= f_tag;
         fifo_pts_ff[tail] <= push_pts;
         fifo_pv_ff[tail]  <= f_pv;
      end
   end

   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem_ff[pool_waddr] <= pool_wdata;
      end
      pool_rdata_ff <= pool_mem_ff[pool_raddr];
   end

endmodule

// File: rtl/dtsr_checker.sv
// Port-level checker for the decode timestamp reorder block, with its bind.
`timescale 1ns / 1ps

module dtsr_checker
   import dtsr_pkg::*;
#(
   parameter int TAG_BITS = 16,
   localparam int RSP_W = ((TAG_BITS + 2 * TS_W + 1 + 7) / 8) * 8
)
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   ts_type c_pts;
   logic   c_pv;
   ts_type c_dts;
   ts_type prior_dts_ff;
   logic   seen_ff;

   assign c_pts = rsp_tdata[TAG_BITS +: TS_W];
   assign c_pv  = rsp_tdata[TAG_BITS + TS_W];
   assign c_dts = rsp_tdata[TAG_BITS + TS_W + 1 +: TS_W];

   // Tracks the dts of the last item taken from the result channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         prior_dts_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         seen_ff      <= 1'b1;
         prior_dts_ff <= c_dts;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   a_dts_rising: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && seen_ff |->
         ($signed(c_dts) > $signed(prior_dts_ff)) ||
         (c_dts == prior_dts_ff && c_dts == TS_MAX))
      else $error("dts did not increase");

   a_pts_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (!c_pv || $signed(c_pts) >= $signed(c_dts)) && (c_pv || c_pts == '0))
      else $error("pts below dts or missing pts not zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind dts_reorder_synthesizer dtsr_checker #(.TAG_BITS(TAG_BITS)) u_dtsr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: verif/tb_dts_reorder_synthesizer.sv
// Self-checking testbench for the decode timestamp reorder block.
`timescale 1ns / 1ps

module tb_dts_reorder_synthesizer;
   import dtsr_pkg::*;

   localparam int DEPTH = 6;
   localparam int TAG_W = 16;
   localparam int REQ_W = ((TAG_W + 2 * TS_W + 2 + 7) / 8) * 8;
   localparam int RSP_W = ((TAG_W + 2 * TS_W + 1 + 7) / 8) * 8;
   localparam int PTS_LO = TAG_W;
   localparam int PV_BIT = TAG_W + TS_W;
   localparam int DTS_LO = PV_BIT + 1;
   localparam int DV_BIT = DTS_LO + TS_W;
   localparam int SETTLE_CYCLES = 100;
   localparam ts_type NEG_MAX = 64'h8000_0000_0000_0001;

   typedef enum logic {FUNC_PUSH = 1'b0, FUNC_FLUSH = 1'b1} func_type;
   typedef enum logic {MODE_VIDEO = 1'b0, MODE_AUDIO = 1'b1} mode_type;

   typedef struct {
      logic [TAG_W-1:0] tag;
      ts_type           pts;
      logic             pts_ok;
   } held_packet_type;

   typedef struct {
      logic [TAG_W-1:0] tag;
      ts_type           pts;
      logic             pts_ok;
      ts_type           dts;
      logic             last;
   } stamp_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic             csr_valid;
   logic             csr_ready;
   logic             csr_data;

   // Shadow of the block state.
   held_packet_type reorder_q[$];
   ts_type          pts_pool_q[$];
   stamp_type       due_stamps[$];
   ts_type          prior_dts;
   logic            prior_dts_ok;
   mode_type        cur_mode;

   int     error_count;
   int     offered;
   int     long_hold_req;
   logic   calm;
   ts_type stream_clock;

   dts_reorder_synthesizer #(
      .REORDER_DEPTH_P(DEPTH),
      .TAG_BITS(TAG_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic ts_less(ts_type a, ts_type b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic ts_type bump(ts_type x);
      return (x == TS_MAX) ? x : x + 1;
   endfunction

   // Guard applied to every packet that leaves; queues the expected result.
   function automatic void guard_stamp(logic [TAG_W-1:0] tag, ts_type pts, logic pv,
                                       ts_type dts, logic dv, logic last);
      stamp_type s;
      if (!pv) pts = '0;
      if (!dv) dts = pv ? pts : (prior_dts_ok ? bump(prior_dts) : '0);
      if (pv && ts_less(pts, dts)) dts = pts;
      if (prior_dts_ok && !ts_less(prior_dts, dts)) dts = bump(prior_dts);
      if (pv && ts_less(pts, dts)) pts = dts;
      prior_dts = dts;
      prior_dts_ok = 1'b1;
      s.tag = tag;
      s.pts = pts;
      s.pts_ok = pv;
      s.dts = dts;
      s.last = last;
      due_stamps.push_back(s);
   endfunction

   // The oldest packet leaves with the smallest pts still in the pool.
   function automatic void release_oldest(logic flushing);
      held_packet_type h;
      int mi;
      ts_type d;
      h = reorder_q.pop_front();
      mi = 0;
      for (int i = 1; i < pts_pool_q.size(); i++)
         if (ts_less(pts_pool_q[i], pts_pool_q[mi])) mi = i;
      d = pts_pool_q[mi];
      pts_pool_q[mi] = pts_pool_q[pts_pool_q.size() - 1];
      pts_pool_q.pop_back();
      guard_stamp(h.tag, h.pts, h.pts_ok, d, 1'b1, !flushing || reorder_q.size() == 0);
   endfunction

   function automatic void model_item(func_type f, logic [TAG_W-1:0] tag, ts_type pts,
                                      logic pv, ts_type dts, logic dv);
      held_packet_type h;
      if (f == FUNC_FLUSH) begin
         while (reorder_q.size() > 0) release_oldest(1'b1);
      end else if (cur_mode == MODE_AUDIO || (dv && reorder_q.size() == 0)) begin
         guard_stamp(tag, pts, pv, dts, dv, 1'b1);
      end else begin
         h.tag = tag;
         h.pts = pv ? pts : '0;
         h.pts_ok = pv;
         reorder_q.push_back(h);
         pts_pool_q.push_back(h.pts);
         if (reorder_q.size() > DEPTH) release_oldest(1'b0);
      end
   endfunction

   task automatic offer_packet(func_type f, logic [TAG_W-1:0] tag, ts_type pts, logic pv,
                               ts_type dts, logic dv);
      logic [REQ_W-1:0] word;
      word = '0;
      word[TAG_W-1:0] = tag;
      word[PTS_LO +: TS_W] = pts;
      word[PV_BIT] = pv;
      word[DTS_LO +: TS_W] = dts;
      word[DV_BIT] = dv;
      if (!calm && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      model_item(f, tag, pts, pv, dts, dv);
      offered++;
   endtask

   task automatic offer_flush();
      offer_packet(FUNC_FLUSH, 16'($urandom), {$urandom, $urandom}, 1'($urandom),
                   {$urandom, $urandom}, 1'($urandom));
   endtask

   // Waits until every expected result is out and the block has gone quiet.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_stamps.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(mode_type m);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      cur_mode = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A present timestamp stays near the stream position or is NEG_MAX; an absent one is any pattern.
   function automatic ts_type stray_stamp(logic present);
      int off;
      if (!present) return {$urandom, $urandom};
      if ($urandom_range(0, 5) == 0) return NEG_MAX;
      off = int'($urandom_range(0, 2000000)) - 1000000;
      return stream_clock + ts_type'(longint'(off));
   endfunction

   task automatic play_noise();
      logic pv;
      logic dv;
      func_type f;
      pv = 1'($urandom);
      dv = 1'($urandom);
      f = ($urandom_range(0, 4) == 0) ? FUNC_FLUSH : FUNC_PUSH;
      offer_packet(f, 16'($urandom), stray_stamp(pv), pv, stray_stamp(dv), dv);
   endtask

   // A run of frames in decode order with the usual I/P/B presentation pattern.
   task automatic play_stream(int frames);
      ts_type step;
      ts_type pts;
      ts_type dts;
      int offs;
      logic pv;
      logic dv;
      step = ts_type'($urandom_range(1, 4000));
      if ($urandom_range(0, 7) == 0) stream_clock += {$urandom_range(0, 255), $urandom};
      for (int k = 0; k < frames; k++) begin
         offs = (k % 3 == 0) ? k + 2 : k - 1;
         pts = stream_clock + step * ts_type'(offs);
         dts = stream_clock + step * ts_type'(k) - step;
         pv = ($urandom_range(0, 9) != 0);
         dv = (k == 0) || ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 11) == 0) pts = pts - ts_type'($urandom_range(0, 20000));
         offer_packet(FUNC_PUSH, 16'($urandom), pts, pv, dts, dv);
      end
      stream_clock += step * ts_type'(frames + 4);
      if ($urandom_range(0, 2) != 0) offer_flush();
   endtask

   task automatic test_video_directed();
      offer_flush();
      offer_packet(FUNC_PUSH, 16'hFFFF, NEG_MAX, 1'b1, NEG_MAX, 1'b1);
      offer_packet(FUNC_PUSH, 16'h0000, 64'hDEAD_BEEF_0123_4567, 1'b0, 64'h55, 1'b0);
      offer_packet(FUNC_PUSH, 16'h0001, 64'd900, 1'b1, 64'd0, 1'b0);
      // The dts of a packet that goes into the buffer is ignored.
      offer_packet(FUNC_PUSH, 16'h0002, -64'sd5, 1'b1, 64'd123, 1'b1);
      offer_packet(FUNC_PUSH, 16'h0003, 64'd40, 1'b1, 64'd0, 1'b0);
      offer_packet(FUNC_PUSH, 16'h0004, 64'd10, 1'b1, 64'd0, 1'b0);
      offer_packet(FUNC_PUSH, 16'h0005, 64'd20, 1'b0, 64'd0, 1'b0);
      offer_packet(FUNC_PUSH, 16'h0006, 64'd30, 1'b1, 64'd0, 1'b0);
      offer_packet(FUNC_PUSH, 16'h0007, -64'sd20, 1'b1, 64'd7, 1'b1);
      offer_flush();
      offer_flush();
   endtask

   task automatic test_audio_directed();
      offer_packet(FUNC_PUSH, 16'h0100, 64'd1000, 1'b1, 64'd0, 1'b0);
      offer_packet(FUNC_PUSH, 16'h0101, 64'd1010, 1'b0, 64'd0, 1'b0);
      offer_packet(FUNC_PUSH, 16'h0102, 64'd990, 1'b1, 64'd995, 1'b1);
      write_mode(MODE_AUDIO);
      // Audio pushes go around the packets still held in the buffer.
      offer_packet(FUNC_PUSH, 16'h0103, 64'd2000, 1'b1, 64'd0, 1'b0);
      offer_packet(FUNC_PUSH, 16'h0104, 64'h0123_4567_89AB_CDEF, 1'b0, 64'd2100, 1'b1);
      offer_flush();
      offer_flush();
   endtask

   task automatic test_backpressure();
      int target;
      target = offered + 30;
      long_hold_req = 400;
      while (offered < target) play_stream($urandom_range(4, 10));
   endtask

   task automatic test_random_traffic(int count);
      int target;
      target = offered + count;
      while (offered < target) begin
         if ($urandom_range(0, 3) != 0) play_stream($urandom_range(3, 12));
         else repeat ($urandom_range(1, 4)) play_noise();
      end
   endtask

   // Run last: once the previous dts reaches the top it can never come down.
   task automatic test_saturation();
      offer_flush();
      offer_packet(FUNC_PUSH, 16'h0200, TS_MAX, 1'b1, TS_MAX, 1'b1);
      offer_packet(FUNC_PUSH, 16'h0201, 64'd0, 1'b0, -64'sd3, 1'b1);
      offer_packet(FUNC_PUSH, 16'h0202, 64'd7, 1'b1, 64'd7, 1'b1);
      offer_packet(FUNC_PUSH, 16'h0203, TS_MAX, 1'b1, 64'd0, 1'b0);
      offer_flush();
   endtask

   // Result acceptance pacing, with the long hold-off counted here.
   initial begin : result_pacer
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req > 0) begin
            hold = long_hold_req;
            long_hold_req = 0;
         end else if (hold == 0 && !calm && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 16);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      stamp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_stamps.size() == 0) begin
            $error("result with tag %0h arrived with none expected", rsp_tdata[TAG_W-1:0]);
            error_count++;
         end else begin
            want = due_stamps.pop_front();
            if (rsp_tdata[TAG_W-1:0] !== want.tag) begin
               $error("tag_out: expected %0h, actual %0h", want.tag, rsp_tdata[TAG_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[PTS_LO +: TS_W] !== want.pts) begin
               $error("pts_out: expected %0d, actual %0d", $signed(want.pts),
                      $signed(rsp_tdata[PTS_LO +: TS_W]));
               error_count++;
            end
            if (rsp_tdata[PV_BIT] !== want.pts_ok) begin
               $error("pts_out_valid: expected %0b, actual %0b", want.pts_ok,
                      rsp_tdata[PV_BIT]);
               error_count++;
            end
            if (rsp_tdata[DTS_LO +: TS_W] !== want.dts) begin
               $error("dts_out: expected %0d, actual %0d", $signed(want.dts),
                      $signed(rsp_tdata[DTS_LO +: TS_W]));
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_out: expected %0b, actual %0b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #5ms;
      $display("tb_dts_reorder_synthesizer: errors");
      $finish;
   end

   initial begin : test_sequence
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      error_count = 0;
      offered = 0;
      long_hold_req = 0;
      calm = 1'b0;
      stream_clock = 64'd1000;
      prior_dts = '0;
      prior_dts_ok = 1'b0;
      cur_mode = MODE_VIDEO;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_mode(MODE_VIDEO);
      test_video_directed();
      test_audio_directed();
      write_mode(MODE_VIDEO);
      test_backpressure();
      test_random_traffic(200);
      write_mode(MODE_AUDIO);
      test_random_traffic(60);
      write_mode(MODE_VIDEO);
      calm = 1'b1;
      test_random_traffic(100);
      test_saturation();
      settle();

      if (due_stamps.size() != 0) begin
         $error("%0d expected results never arrived", due_stamps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_dts_reorder_synthesizer: clean");
      end else begin
         $display("tb_dts_reorder_synthesizer: errors");
      end
      $finish;
   end

endmodule
